### rtl/ucbp_pkg.sv
// ---------------------------------------------------------------------------
// ucbp_pkg: shared types and constants for the universal code bit packer
// Holds command codes, sequencer states and the bit-run record.
// ---------------------------------------------------------------------------
package ucbp_pkg;

  localparam int WordBits = 64;
  localparam int FibTerms = 93;

  typedef enum logic [2:0] {
    CMD_BIN   = 3'd0,
    CMD_UNARY = 3'd1,
    CMD_GAMMA = 3'd2,
    CMD_DELTA = 3'd3,
    CMD_FIB   = 3'd4,
    CMD_FLUSH = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FSCAN,
    ST_FDOWN,
    ST_SEG,
    ST_PUSH,
    ST_OUT,
    ST_DONE
  } state_t;

  // One run of bits handed to the packer: count bits of data, MSB first.
  typedef struct packed {
    logic        go;
    logic [63:0] data;
    logic [6:0]  count;
  } seg_t;

endpackage

### rtl/universal_code_bit_packer.sv
// ---------------------------------------------------------------------------
// universal_code_bit_packer: binary, unary, gamma, delta and Fibonacci packer
// A small sequencer turns each item into runs of bits and feeds them to a
// shared 64-bit packer; full words leave through an output register.
// ---------------------------------------------------------------------------
//   Channel   Signals                                   Direction
//   input     in_valid, in_stall, cmd, value, width      into block
//   output    out_valid, out_stall, word_valid, word,    out of block
//             word_bits, code_length, error, last
//
// An item passes through an accept state, a setup state, a packing state
// that walks the bit-run slots (a run of more than 64 zeros is pushed in
// 64-bit pieces) and an output state with one result word per transfer. A
// Fibonacci item first scans the table upward term by term and then walks
// back down, each step the single add/compare step of the table walk.
// in_stall is high while an item is in work.
// Reset clears the accumulator and the sequencer; out_stall holds a result.
module universal_code_bit_packer #(
  parameter int MAX_UNARY = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [63:0] value,
  input  logic [6:0]  width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        word_valid,
  output logic [63:0] word,
  output logic [6:0]  word_bits,
  output logic [8:0]  code_length,
  output logic        error,
  output logic        last
);

  localparam int Limit = (MAX_UNARY < 255) ? MAX_UNARY : 255;

  ucbp_pkg::state_t state, state_next;

  logic [2:0]  cmd_r;
  logic [63:0] val_r;
  logic [6:0]  blen;
  logic [2:0]  blen_l;
  logic        err_r;
  logic [8:0]  len_r;

  // Segment list: up to four runs of bits.
  logic [63:0] sdata [4];
  logic [8:0]  scnt  [4];
  logic [2:0]  sidx;
  logic [8:0]  sleft;

  // Fibonacci walk: fterm holds the term at index fk, fnext the one above.
  logic [6:0]  fk;
  logic [63:0] frem;
  logic [63:0] fbits_hi;
  logic [63:0] fbits_lo;
  logic [63:0] fterm;
  logic [63:0] fnext;

  // Result buffer.
  logic [63:0] rword [4];
  logic [6:0]  rbits [4];
  logic [2:0]  rcnt;
  logic [2:0]  ridx;

  ucbp_pkg::seg_t seg;
  logic        pk_full;
  logic [63:0] pk_word;
  logic [63:0] pk_part;
  logic [5:0]  pk_fill;
  logic        pk_flush;

  ucbp_packer u_pack (
    .clk(clk), .rst(rst), .seg(seg), .flush(pk_flush),
    .full(pk_full), .full_word(pk_word),
    .partial_word(pk_part), .fill_count(pk_fill)
  );

  // Bit length of the incoming value.
  always_comb begin
    blen = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (value[i]) blen = 7'(i + 1);
    end
    blen_l = 3'd0;
    for (int i = 0; i < 7; i++) begin
      if (blen[i]) blen_l = 3'(i + 1);
    end
  end

  // Current run: at most 64 bits per cycle.
  always_comb begin
    seg.go    = (state == ucbp_pkg::ST_PUSH) && (sidx < 3'd4) && (sleft != 9'd0);
    seg.count = (sleft > 9'd64) ? 7'd64 : sleft[6:0];
    seg.data  = sdata[sidx[1:0]] >> (sleft - 9'({2'b00, seg.count}));
    if (sleft > 9'd64) seg.data = 64'd0;
  end

  assign pk_flush = (state == ucbp_pkg::ST_SEG) && (cmd_r == ucbp_pkg::CMD_FLUSH);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ucbp_pkg::ST_IDLE: if (in_valid) begin
        if (cmd == ucbp_pkg::CMD_FIB && value != 64'd0) state_next = ucbp_pkg::ST_FSCAN;
        else state_next = ucbp_pkg::ST_SEG;
      end
      ucbp_pkg::ST_FSCAN:
        if (fk == 7'(ucbp_pkg::FibTerms - 1) || fnext > val_r) state_next = ucbp_pkg::ST_FDOWN;
      ucbp_pkg::ST_FDOWN: if (fk == 7'd1) state_next = ucbp_pkg::ST_SEG;
      ucbp_pkg::ST_SEG:   state_next = ucbp_pkg::ST_PUSH;
      ucbp_pkg::ST_PUSH:  if (!seg.go && sidx >= 3'd3) state_next = ucbp_pkg::ST_OUT;
      ucbp_pkg::ST_OUT:   if (!out_stall && ridx + 3'd1 >= rcnt) state_next = ucbp_pkg::ST_IDLE;
      ucbp_pkg::ST_DONE:  state_next = ucbp_pkg::ST_IDLE;
      default:            state_next = ucbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ucbp_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Outputs.
  always_comb begin
    in_stall    = (state != ucbp_pkg::ST_IDLE);
    out_valid   = (state == ucbp_pkg::ST_OUT);
    word_valid  = (rcnt != 3'd0);
    word        = (rcnt != 3'd0) ? rword[ridx[1:0]] : 64'd0;
    word_bits   = (rcnt != 3'd0) ? rbits[ridx[1:0]] : 7'd0;
    code_length = len_r;
    error       = err_r;
    last        = (rcnt == 3'd0) || (ridx + 3'd1 == rcnt);
  end

  // Item capture, Fibonacci walk, segment setup and result collection.
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
      ridx <= '0;
      sidx <= '0;
    end else begin
      case (state)
        ucbp_pkg::ST_IDLE: if (in_valid) begin
          cmd_r <= cmd;
          val_r <= value;
          fk    <= 7'd1;
          fterm <= 64'd1;
          fnext <= 64'd2;
          frem  <= value;
          fbits_hi <= '0;
          fbits_lo <= '0;
          rcnt  <= '0;
          ridx  <= '0;
          for (int i = 0; i < 4; i++) begin
            sdata[i] <= '0;
            scnt[i]  <= '0;
          end
          err_r <= 1'b0;
          len_r <= '0;
          case (ucbp_pkg::cmd_t'(cmd))
            ucbp_pkg::CMD_BIN: begin
              sdata[0] <= value;
              scnt[0]  <= {2'b00, (width > 7'd64) ? 7'd64 : width};
              len_r    <= {2'b00, (width > 7'd64) ? 7'd64 : width};
            end
            ucbp_pkg::CMD_UNARY: begin
              if (value > 64'(Limit)) err_r <= 1'b1;
              else begin
                sdata[0] <= 64'd0;
                scnt[0]  <= value[8:0];
                sdata[1] <= 64'd1;
                scnt[1]  <= 9'd1;
                len_r    <= value[8:0] + 9'd1;
              end
            end
            ucbp_pkg::CMD_GAMMA: begin
              if (value == 64'd0) err_r <= 1'b1;
              else begin
                scnt[0]  <= {2'b00, blen - 7'd1};
                sdata[1] <= value;
                scnt[1]  <= {2'b00, blen};
                len_r    <= {1'b0, blen, 1'b0} - 9'd1;
              end
            end
            ucbp_pkg::CMD_DELTA: begin
              if (value == 64'd0) err_r <= 1'b1;
              else begin
                scnt[0]  <= {6'd0, blen_l - 3'd1};
                sdata[1] <= {57'd0, blen};
                scnt[1]  <= {6'd0, blen_l};
                sdata[2] <= value;
                scnt[2]  <= {2'b00, blen - 7'd1};
                len_r    <= {5'd0, blen_l, 1'b0} - 9'd1 + {2'b00, blen} - 9'd1;
              end
            end
            ucbp_pkg::CMD_FIB: begin
              if (value == 64'd0) err_r <= 1'b1;
            end
            default: ;
          endcase
        end
        ucbp_pkg::ST_FSCAN: begin
          if (fk == 7'(ucbp_pkg::FibTerms - 1) || fnext > val_r) begin
            scnt[0] <= {2'b00, (fk > 7'd64) ? 7'd64 : fk};
            scnt[1] <= {2'b00, (fk > 7'd64) ? fk - 7'd64 : 7'd0};
            scnt[2] <= 9'd1;
            sdata[2] <= 64'd1;
            len_r   <= {2'b00, fk} + 9'd1;
          end else begin
            fk    <= fk + 7'd1;
            fterm <= fnext;
            fnext <= fterm + fnext;
          end
        end
        ucbp_pkg::ST_FDOWN: begin
          // Bit for term k sits at stream position k-1, MSB first.
          if (fterm <= frem) begin
            frem <= frem - fterm;
            if (fk <= 7'd64) fbits_hi[6'(7'd64 - fk)] <= 1'b1;
            else             fbits_lo[6'(7'd64 - (fk - 7'd64))] <= 1'b1;
          end
          // Step one term down: the lower term is the difference of the pair.
          if (fk != 7'd1) begin
            fk    <= fk - 7'd1;
            fterm <= fnext - fterm;
            fnext <= fterm;
          end
        end
        ucbp_pkg::ST_SEG: begin
          sidx  <= 3'd0;
          sleft <= scnt[0];
          if (cmd_r == ucbp_pkg::CMD_FIB && !err_r) begin
            sdata[0] <= fbits_hi >> (7'd64 - scnt[0][6:0]);
            sdata[1] <= (scnt[1] == 9'd0) ? 64'd0 :
                        fbits_lo >> (7'd64 - scnt[1][6:0]);
          end
          if (cmd_r == ucbp_pkg::CMD_FLUSH && pk_fill != 6'd0) begin
            rword[0] <= pk_part;
            rbits[0] <= {1'b0, pk_fill};
            rcnt     <= 3'd1;
          end
        end
        ucbp_pkg::ST_PUSH: begin
          if (seg.go) begin
            if (pk_full) begin
              rword[rcnt[1:0]] <= pk_word;
              rbits[rcnt[1:0]] <= 7'd64;
              rcnt <= rcnt + 3'd1;
            end
            if (sleft > 9'd64) sleft <= sleft - 9'd64;
            else begin
              sidx  <= sidx + 3'd1;
              sleft <= (sidx < 3'd3) ? scnt[sidx[1:0] + 2'd1] : 9'd0;
            end
          end else if (sleft == 9'd0 && sidx < 3'd3) begin
            sidx  <= sidx + 3'd1;
            sleft <= scnt[sidx[1:0] + 2'd1];
          end
        end
        ucbp_pkg::ST_OUT: if (!out_stall) ridx <= ridx + 3'd1;
        default: ;
      endcase
    end
  end

endmodule

### rtl/ucbp_packer.sv
// ---------------------------------------------------------------------------
// ucbp_packer: 64-bit MSB-first accumulator
// Appends a run of up to 64 bits per cycle by left-aligning it and shifting
// it behind pending bits; reports a completed word and the spill-over bits.
// ---------------------------------------------------------------------------
module ucbp_packer (
  input  logic                 clk,
  input  logic                 rst,
  input  ucbp_pkg::seg_t       seg,
  input  logic                 flush,
  output logic                 full,
  output logic [63:0]          full_word,
  output logic [63:0]          partial_word,
  output logic [5:0]           fill_count
);

  logic [127:0] span;
  logic [7:0]   total;
  logic [63:0]  data_al;

  // Left-align the run, then place it after the pending bits.
  always_comb begin
    data_al = (seg.count == 7'd0) ? 64'd0 : (seg.data << (7'd64 - seg.count));
    span    = {partial_word, 64'd0} | ({data_al, 64'd0} >> fill_count);
    total   = {2'b00, fill_count} + {1'b0, seg.count};
    full    = seg.go && (total >= 8'd64);
    full_word = span[127:64];
  end

  // Accumulator update.
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      partial_word <= '0;
      fill_count   <= '0;
    end else if (seg.go) begin
      partial_word <= full ? span[63:0] : span[127:64];
      fill_count   <= total[5:0];
    end
  end

endmodule
